// ----- hw/rtl/lzwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared constants and the request type of the hash unit.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int unsigned LIMIT_W         = 17;
    localparam int unsigned KEY_PREFIX_W    = 16;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned KEY_W           = KEY_PREFIX_W + BYTE_W;
    localparam int unsigned HASH_W          = 32;
    localparam int unsigned OUT_CODE_W      = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 17'd65536;
    localparam logic [LIMIT_W-1:0] FIRST_FREE_CODE = 17'd257;
    localparam logic [HASH_W-1:0]  HASH_MULT       = 32'd2654435761;
    localparam int unsigned        KEY_SHIFT       = 11;
    localparam int unsigned        FOLD_SHIFT      = 15;

    typedef struct packed {
        logic                    start;
        logic [KEY_PREFIX_W-1:0] prefix;
        logic [BYTE_W-1:0]       data;
    } hash_req_t;

endpackage

// ----- hw/rtl/lzw_byte_compressor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW byte compressor
// Compresses a byte stream into LZW codes using a hashed dictionary memory.
// ----------------------------------------------------------------------------
// Each byte is one request; a byte gives zero, one or two codes, the last one
// marked final when the byte ends the stream. The first byte of a stream is
// taken as the prefix without a lookup. Any other byte is hashed (through more
// registers when HASH_SLOTS is not a power of two), then each dictionary probe
// reads one slot through the single memory read port, and each emitted code
// waits for the output. After reset and after every final code the dictionary
// memory is cleared one slot per cycle, during which no byte is taken;
// configuration writes are accepted at any time.
module lzw_byte_compressor_top #(
    parameter int unsigned CODE_BITS  = 16,
    parameter int unsigned HASH_SLOTS = 131072
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [lzwc_pkg::LIMIT_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lzwc_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                  stream_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lzwc_pkg::OUT_CODE_W-1:0]       out_code,
    output logic                                  final_code
);
    import lzwc_pkg::*;

    localparam int unsigned IDX_W   = $clog2(HASH_SLOTS);
    localparam int unsigned NFC_W   = CODE_BITS + 1;
    localparam int unsigned ENTRY_W = 1 + CODE_BITS + BYTE_W + CODE_BITS;
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(HASH_SLOTS - 1);
    localparam logic [LIMIT_W-1:0] CODE_CAP  = LIMIT_W'(1) << CODE_BITS;
    localparam logic [NFC_W-1:0]   NFC_RESET = NFC_W'(FIRST_FREE_CODE);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_MISS  = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [CODE_BITS-1:0] prefix_reg, prefix_next;
    logic                 pvalid_reg, pvalid_next;
    logic [NFC_W-1:0]     nfc_reg, nfc_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [IDX_W-1:0]     probe_reg, probe_next;
    logic [BYTE_W-1:0]    byte_reg;
    logic                 last_reg;
    logic [CODE_BITS-1:0] emit_reg, emit_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_CODE_W-1:0] out_code_reg, out_code_next;
    logic                 out_final_reg, out_final_next;

    hash_req_t            hash_req;
    logic                 hash_done;
    logic [IDX_W-1:0]     hash_idx;

    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 ent_valid;
    logic [CODE_BITS-1:0] ent_prefix;
    logic [BYTE_W-1:0]    ent_byte;
    logic [CODE_BITS-1:0] ent_code;

    logic                 in_fire;
    logic                 out_free;
    logic [LIMIT_W-1:0]   limit_eff;
    logic                 room;

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign limit_eff = (limit_reg > CODE_CAP) ? CODE_CAP : limit_reg;
    assign room      = LIMIT_W'(nfc_reg) < limit_eff;

    assign ent_valid  = ram_rdata[ENTRY_W-1];
    assign ent_prefix = ram_rdata[ENTRY_W-2 -: CODE_BITS];
    assign ent_byte   = ram_rdata[CODE_BITS +: BYTE_W];
    assign ent_code   = ram_rdata[CODE_BITS-1:0];

    assign hash_req.start  = (state_reg == S_IDLE) && in_fire && pvalid_reg;
    assign hash_req.prefix = KEY_PREFIX_W'(prefix_reg);
    assign hash_req.data   = data_byte;

    lzwc_hash #(
        .HASH_SLOTS(HASH_SLOTS)
    ) u_hash (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (hash_req),
        .done (hash_done),
        .idx  (hash_idx)
    );

    lzwc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(HASH_SLOTS)
    ) u_dict (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(ram_wdata),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        pvalid_next    = pvalid_reg;
        nfc_next       = nfc_reg;
        addr_next      = addr_reg;
        probe_next     = probe_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_code_next  = out_code_reg;
        out_final_next = out_final_reg;
        ram_we         = 1'b0;
        ram_wdata      = '0;
        in_ready       = (state_reg == S_IDLE);

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!pvalid_reg)
                    begin
                        prefix_next = CODE_BITS'(data_byte);
                        pvalid_next = 1'b1;
                        state_next  = stream_end ? S_FINAL : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    addr_next  = hash_idx;
                    probe_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (ent_valid && ent_prefix == prefix_reg && ent_byte == byte_reg)
                begin
                    prefix_next = ent_code;
                    state_next  = last_reg ? S_FINAL : S_IDLE;
                end
                else if (!ent_valid || probe_reg == LAST_IDX)
                begin
                    if (!ent_valid && room)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, prefix_reg, byte_reg, nfc_reg[CODE_BITS-1:0]};
                        nfc_next  = nfc_reg + 1'b1;
                    end
                    emit_next   = prefix_reg;
                    prefix_next = CODE_BITS'(byte_reg);
                    state_next  = S_MISS;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    addr_next  = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_MISS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = OUT_CODE_W'(emit_reg);
                    out_final_next = 1'b0;
                    state_next     = last_reg ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = OUT_CODE_W'(prefix_reg);
                    out_final_next = 1'b1;
                    prefix_next    = '0;
                    pvalid_next    = 1'b0;
                    nfc_next       = NFC_RESET;
                    addr_next      = '0;
                    state_next     = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            limit_reg     <= LIMIT_RESET;
            prefix_reg    <= '0;
            pvalid_reg    <= 1'b0;
            nfc_reg       <= NFC_RESET;
            addr_reg      <= '0;
            probe_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            pvalid_reg    <= pvalid_next;
            nfc_reg       <= nfc_next;
            addr_reg      <= addr_next;
            probe_reg     <= probe_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= data_byte;
            last_reg <= stream_end;
        end
        emit_reg      <= emit_next;
        out_code_reg  <= out_code_next;
        out_final_reg <= out_final_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_code   = out_code_reg;
    assign final_code = out_final_reg;

    a_clear_no_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !pvalid_reg)
        else $error("Dictionary clear while a prefix is held.");

    a_clear_out_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && out_valid_reg) |-> out_final_reg)
        else $error("Non-final code pending during dictionary clear.");

    a_nfc_floor: assert property (@(posedge clk) disable iff (!rst_n)
        nfc_reg >= NFC_RESET)
        else $error("Next free code fell below the first free code.");

    a_hash_only_with_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HASH || state_reg == S_READ || state_reg == S_CHECK)
        |-> pvalid_reg)
        else $error("Dictionary lookup without a held prefix.");

endmodule

// ----- hw/rtl/lzwc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzwc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lzwc_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW hash unit
// Multiplicative hash of the (prefix, byte) key reduced to a slot index.
// ----------------------------------------------------------------------------
module lzwc_hash #(
    parameter int unsigned HASH_SLOTS = 131072
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lzwc_pkg::hash_req_t           req,
    output logic                          done,
    output logic [$clog2(HASH_SLOTS)-1:0] idx
);
    import lzwc_pkg::*;

    localparam int unsigned IDX_W = $clog2(HASH_SLOTS);

    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  mix;
    logic [HASH_W-1:0] prod_reg;
    logic              mul_vld_reg;
    logic [HASH_W-1:0] fold;

    assign key  = {req.prefix, req.data};
    assign mix  = key ^ (key >> KEY_SHIFT);
    assign fold = prod_reg ^ (prod_reg >> FOLD_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= HASH_W'(HASH_W'(mix) * HASH_MULT);
        end
    end

    generate
        if ((HASH_SLOTS & (HASH_SLOTS - 1)) == 0)
        begin : g_mask
            assign done = mul_vld_reg;
            assign idx  = fold[IDX_W-1:0];
        end
        else
        begin : g_recip
            // The quotient is estimated with a rounded-down reciprocal, so it is
            // exact or one too small; the remainder needs at most one subtraction.
            localparam int unsigned       REM_W      = HASH_W + 1;
            localparam logic [63:0]       RECIP_FULL =
                (64'd1 << (HASH_W + IDX_W)) / 64'(HASH_SLOTS);
            localparam logic [HASH_W-1:0] RECIP_LO   = RECIP_FULL[HASH_W-1:0];
            localparam logic [REM_W-1:0]  SLOTS_C    = REM_W'(HASH_SLOTS);

            logic [2*HASH_W-1:0] mul_lo;
            logic [2*HASH_W:0]   est_prod;
            logic [HASH_W-1:0]   fold_reg;
            logic [REM_W-1:0]    quot_reg;
            logic [REM_W-1:0]    rem_reg;
            logic [REM_W-1:0]    rem_fix;
            logic                quot_vld_reg;
            logic                rem_vld_reg;

            assign mul_lo   = 64'(fold) * 64'(RECIP_LO);
            assign est_prod = {1'b0, fold, {HASH_W{1'b0}}} + {1'b0, mul_lo};
            assign rem_fix  = (rem_reg >= SLOTS_C) ? (rem_reg - SLOTS_C) : rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    quot_vld_reg <= 1'b0;
                    rem_vld_reg  <= 1'b0;
                end
                else
                begin
                    quot_vld_reg <= mul_vld_reg;
                    rem_vld_reg  <= quot_vld_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (mul_vld_reg)
                begin
                    fold_reg <= fold;
                    quot_reg <= REM_W'(est_prod >> (HASH_W + IDX_W));
                end
                if (quot_vld_reg)
                begin
                    rem_reg <= {1'b0, fold_reg} - REM_W'(quot_reg * SLOTS_C);
                end
            end

            assign done = rem_vld_reg;
            assign idx  = rem_fix[IDX_W-1:0];
        end
    endgenerate

endmodule

// ----- tb/lzw_byte_compressor_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW byte compressor testbench
// Sends byte streams through the compressor with random gaps and output stalls.
// A scoreboard keeps its own hashed dictionary, predicts every emitted code and
// checks the codes in order while the code limit is swept across its range.
// ----------------------------------------------------------------------------
module lzw_byte_compressor_top_tb;

    import lzwc_pkg::*;

    // A small table keeps the clearing pass short and lets one stream fill it.
    localparam int unsigned TB_CODE_BITS   = 16;
    localparam int unsigned TB_SLOTS       = 1024;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES  = 50;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [OUT_CODE_W-1:0] code_t;

    typedef struct packed {
        code_t code_val;
        logic  is_final;
    } code_rec_t;

    class lzw_scoreboard;
        bit                slot_used   [TB_SLOTS];
        bit [15:0]         slot_prefix [TB_SLOTS];
        bit [7:0]          slot_byte   [TB_SLOTS];
        bit [15:0]         slot_code   [TB_SLOTS];
        int unsigned       slots_taken;
        bit [LIMIT_W-1:0]  code_limit;
        bit [15:0]         prefix;
        bit                prefix_held;
        int unsigned       next_code;
        code_rec_t         expected_codes[$];
        int unsigned       errors;

        function new();
            code_limit = LIMIT_RESET;
            errors     = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
            end
            slots_taken = 0;
            prefix      = '0;
            prefix_held = 1'b0;
            next_code   = FIRST_FREE_CODE;
        endfunction

        function void add_expected(code_rec_t rec);
            expected_codes.insert(expected_codes.size(), rec);
        endfunction

        function int unsigned slot_of(bit [15:0] pfx, bit [7:0] b);
            bit [31:0] key;
            bit [31:0] h;
            key = {8'h00, pfx, b};
            h   = (key ^ (key >> KEY_SHIFT)) * HASH_MULT;
            h   = h ^ (h >> FOLD_SHIFT);
            return h % TB_SLOTS;
        endfunction

        function void note_byte(byte_t b, logic last);
            int unsigned lim;
            int unsigned cap;
            int unsigned idx;
            int unsigned free_idx;
            int unsigned n;
            bit          hit;
            bit [15:0]   hit_code;
            code_rec_t   rec;
            lim = code_limit;
            cap = 1 << TB_CODE_BITS;
            if (lim > cap)
            begin
                lim = cap;
            end
            if (!prefix_held)
            begin
                prefix      = {8'h00, b};
                prefix_held = 1'b1;
            end
            else
            begin
                idx      = slot_of(prefix, b);
                free_idx = TB_SLOTS;
                hit      = 1'b0;
                hit_code = '0;
                for (n = 0; n < TB_SLOTS; n++)
                begin
                    if (!slot_used[idx])
                    begin
                        free_idx = idx;
                        break;
                    end
                    if (slot_prefix[idx] == prefix && slot_byte[idx] == b)
                    begin
                        hit      = 1'b1;
                        hit_code = slot_code[idx];
                        break;
                    end
                    idx = (idx + 1) % TB_SLOTS;
                end
                if (hit)
                begin
                    prefix = hit_code;
                end
                else
                begin
                    rec = '{prefix, 1'b0};
                    add_expected(rec);
                    if (next_code < lim && free_idx < TB_SLOTS && slots_taken < TB_SLOTS)
                    begin
                        slot_used[free_idx]   = 1'b1;
                        slot_prefix[free_idx] = prefix;
                        slot_byte[free_idx]   = b;
                        slot_code[free_idx]   = 16'(next_code);
                        slots_taken++;
                        next_code++;
                    end
                    prefix = {8'h00, b};
                end
            end
            if (last)
            begin
                rec = '{prefix, 1'b1};
                add_expected(rec);
                clear_stream();
            end
        endfunction

        function void check_code(code_t code_val, logic is_final);
            code_rec_t exp_rec;
            if (expected_codes.size() == 0)
            begin
                $error("unexpected code: out_code %0d final_code %0b", code_val, is_final);
                errors++;
                return;
            end
            exp_rec = expected_codes.pop_front();
            if (exp_rec.code_val !== code_val)
            begin
                $error("out_code mismatch: expected %0d, actual %0d",
                       exp_rec.code_val, code_val);
                errors++;
            end
            if (exp_rec.is_final !== is_final)
            begin
                $error("final_code mismatch: expected %0b, actual %0b",
                       exp_rec.is_final, is_final);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_codes.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [LIMIT_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    byte_t                data_byte;
    logic                 stream_end;
    logic                 out_valid;
    logic                 out_ready;
    code_t                out_code;
    logic                 final_code;

    lzw_scoreboard sb;
    int unsigned   burst_left;
    int unsigned   idle_cycles;

    lzw_byte_compressor_top #(
        .CODE_BITS  (TB_CODE_BITS),
        .HASH_SLOTS (TB_SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_code   (out_code),
        .final_code (final_code)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic send_byte(input byte_t b, input logic last);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 12);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        stream_end <= last;
        burst_left--;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_byte(b, last);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.code_limit = value;
    endtask

    task automatic send_stream(input int unsigned len, input int unsigned alpha_size);
        byte_t alpha[16];
        byte_t b;
        foreach (alpha[i])
        begin
            alpha[i] = byte_t'($urandom);
        end
        for (int unsigned k = 0; k < len; k++)
        begin
            if (alpha_size >= 256 || $urandom_range(0, 19) == 0)
            begin
                b = byte_t'($urandom_range(0, 255));
            end
            else
            begin
                b = alpha[$urandom_range(0, alpha_size - 1)];
            end
            send_byte(b, k == len - 1);
        end
    endtask

    // The receiver switches between no stalls, random stalls and a fixed pattern.
    initial
    begin
        logic [15:0] pattern;
        int unsigned hold;
        int unsigned mode;
        out_ready = 1'b0;
        pattern   = '1;
        hold      = 0;
        mode      = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                mode = $urandom_range(0, 2);
                hold = $urandom_range(16, 200);
                pattern = (mode == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
            end
            if (mode == 1)
            begin
                out_ready <= $urandom_range(0, 1);
            end
            else
            begin
                out_ready <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
            end
            hold--;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                sb.check_code(out_code, final_code);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        logic [LIMIT_W-1:0] limit;
        int unsigned        items;
        int unsigned        len;
        int unsigned        alpha_size;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        data_byte  = '0;
        stream_end = 1'b0;
        burst_left = 0;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A stream of one byte, then runs that build and reuse dictionary strings.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);

        // A limit of 258 freezes the dictionary after one entry.
        write_limit(17'd258);
        repeat (4) send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);

        // A limit below the first free code never adds an entry.
        write_limit('0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);

        write_limit(LIMIT_MAX);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);

        for (int unsigned ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: limit = 17'd258;
                1: limit = 17'd259;
                2: limit = 17'd257;
                3: limit = LIMIT_W'($urandom_range(258, 270));
                4: limit = LIMIT_W'($urandom_range(270, 600));
                5: limit = LIMIT_RESET;
                6: limit = LIMIT_MAX;
                7: limit = LIMIT_W'($urandom_range(0, 131071));
                8: limit = LIMIT_W'($urandom_range(600, 1300));
                default: limit = 17'd300;
            endcase
            write_limit(limit);
            items = 0;
            while (items < 8)
            begin
                case ($urandom_range(0, 9))
                    0: len = 1;
                    8, 9: len = $urandom_range(26, 50);
                    default: len = $urandom_range(2, 25);
                endcase
                case ($urandom_range(0, 5))
                    0: alpha_size = 1;
                    1: alpha_size = 2;
                    2: alpha_size = 3;
                    3: alpha_size = 4;
                    4: alpha_size = 16;
                    default: alpha_size = 256;
                endcase
                send_stream(len, alpha_size);
                items += len;
            end
        end

        // One long stream of random bytes fills the whole hash table.
        write_limit(LIMIT_MAX);
        send_stream(1045, 256);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lzwc_pkg.sv
hw/rtl/lzwc_ram.sv
hw/rtl/lzwc_hash.sv
hw/rtl/lzw_byte_compressor_top.sv
tb/lzw_byte_compressor_top_tb.sv
